// ===== hw/rtl/cpalu_pkg.sv =====
// Shared types and constants for the contact-process active list update block.
// Request/response payloads, codes, state encoding and memory command structs.
// No dependencies.
package cpalu_pkg;

   localparam int MAX_SIDE   = 64;
   localparam int SITES      = MAX_SIDE * MAX_SIDE;
   localparam int COORD_W    = 6;
   localparam int SITE_W     = 12;
   localparam int COUNT_W    = 13;
   localparam int SIDE_W     = 7;
   localparam int THR_W      = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [SIDE_W-1:0] SIDE_MIN      = 7'd2;
   localparam logic [SIDE_W-1:0] SIDE_MAX      = 7'd64;
   localparam logic [SIDE_W-1:0] WIDTH_RESET   = 7'd64;
   localparam logic [SIDE_W-1:0] HEIGHT_RESET  = 7'd64;
   localparam logic [THR_W-1:0]  THRESH_RESET  = 17'd32768;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEATH_THRESHOLD = 2'd2;

   typedef enum logic {
      ACT_SEED   = 1'b0,
      ACT_UPDATE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      DIR_X_DOWN = 2'd0,
      DIR_X_UP   = 2'd1,
      DIR_Y_DOWN = 2'd2,
      DIR_Y_UP   = 2'd3
   } direction_type;

   typedef enum logic [2:0] {
      OUT_NONE        = 3'd0,
      OUT_ANNIHILATED = 3'd1,
      OUT_CREATED     = 3'd2,
      OUT_SEEDED      = 3'd3,
      OUT_INVALID     = 3'd4
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_PICK,
      ST_KILL,
      ST_GROW,
      ST_FAIL
   } state_type;

   typedef struct packed {
      logic                action;
      logic [COORD_W-1:0]  site_x;
      logic [COORD_W-1:0]  site_y;
      logic [SITE_W-1:0]   pick_index;
      logic [15:0]         uniform;
      logic [1:0]          direction;
   } req_type;

   typedef struct packed {
      logic [2:0]          outcome;
      logic [COORD_W-1:0]  changed_x;
      logic [COORD_W-1:0]  changed_y;
      logic [COUNT_W-1:0]  occupied_count;
   } rsp_type;

   typedef struct packed {
      logic [SIDE_W-1:0]   grid_w;
      logic [SIDE_W-1:0]   grid_h;
      logic [THR_W-1:0]    death_thr;
   } cfg_type;

   typedef struct packed {
      logic                rd_en;
      logic [COORD_W-1:0]  rd_row;
      logic                wr_en;
      logic [COORD_W-1:0]  wr_row;
      logic [MAX_SIDE-1:0] wr_data;
   } occ_cmd_type;

   typedef struct packed {
      logic                rd_en;
      logic [SITE_W-1:0]   rd_addr;
      logic                wr_en;
      logic [SITE_W-1:0]   wr_addr;
      logic [SITE_W-1:0]   wr_data;
   } list_cmd_type;

endpackage

// ===== hw/rtl/cpalu_occ.sv =====
// Occupancy lattice: one row of sites per memory word, synchronous read.
// Sweeps all rows to empty after reset. Uses cpalu_pkg.
module cpalu_occ (
   input  logic                         clock,
   input  logic                         reset,
   input  cpalu_pkg::occ_cmd_type       cmd,
   output logic [cpalu_pkg::MAX_SIDE-1:0] rd_data,
   output logic                         clearing
);

   logic [cpalu_pkg::MAX_SIDE-1:0] mem [cpalu_pkg::MAX_SIDE];
   logic [cpalu_pkg::MAX_SIDE-1:0] rd_data_ff;
   logic                           clr_ff, clr_in;
   logic [cpalu_pkg::COORD_W-1:0]  clr_row_ff, clr_row_in;

   always_comb begin
      clr_in     = clr_ff;
      clr_row_in = clr_row_ff;
      if (clr_ff) begin
         clr_row_in = clr_row_ff + 1'b1;
         if (clr_row_ff == cpalu_pkg::COORD_W'(cpalu_pkg::MAX_SIDE - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_row_ff <= '0;
      end else begin
         clr_ff     <= clr_in;
         clr_row_ff <= clr_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_row_ff] <= '0;
      end else if (cmd.wr_en) begin
         mem[cmd.wr_row] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_row];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_ff;

endmodule

// ===== hw/rtl/cpalu_list.sv =====
// Occupied-site list memory, one site number per entry, synchronous read.
// Uses cpalu_pkg.
module cpalu_list (
   input  logic                          clock,
   input  cpalu_pkg::list_cmd_type       cmd,
   output logic [cpalu_pkg::SITE_W-1:0]  rd_data
);

   logic [cpalu_pkg::SITE_W-1:0] mem [cpalu_pkg::SITES];
   logic [cpalu_pkg::SITE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cpalu_ctrl.sv =====
// Event sequencer: reads list and lattice, decides the outcome, writes back,
// keeps the occupied count and the response register. Uses cpalu_pkg.
module cpalu_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  cpalu_pkg::cfg_type                 cfg,
   input  logic                               clearing,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  cpalu_pkg::req_type                 req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output cpalu_pkg::rsp_type                 rsp_payload,
   output cpalu_pkg::occ_cmd_type             occ_cmd,
   input  logic [cpalu_pkg::MAX_SIDE-1:0]     occ_row,
   output cpalu_pkg::list_cmd_type            list_cmd,
   input  logic [cpalu_pkg::SITE_W-1:0]       list_data
);

   cpalu_pkg::state_type              state_ff, state_in;
   cpalu_pkg::req_type                req_ff, req_in;
   logic [cpalu_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [cpalu_pkg::SITE_W-1:0]      site_ff, site_in;
   cpalu_pkg::rsp_type                rsp_ff, rsp_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      logic                            go;
      logic                            accept;
      logic [cpalu_pkg::COORD_W-1:0]   x, y, nx, ny;
      logic [cpalu_pkg::SIDE_W-1:0]    x1, y1;
      logic [cpalu_pkg::MAX_SIDE-1:0]  row;

      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      site_in      = site_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      occ_cmd      = '0;
      list_cmd     = '0;
      go           = !rsp_valid_ff || !rsp_stall;
      req_stall    = (state_ff != cpalu_pkg::ST_IDLE) || clearing;
      accept       = req_valid && !req_stall;
      x            = site_ff[cpalu_pkg::COORD_W-1:0];
      y            = site_ff[cpalu_pkg::SITE_W-1:cpalu_pkg::COORD_W];
      x1           = {1'b0, x} + 1'b1;
      y1           = {1'b0, y} + 1'b1;
      nx           = x;
      ny           = y;
      row          = occ_row;

      unique case (state_ff)
         cpalu_pkg::ST_IDLE: begin
            if (accept) begin
               req_in = req_payload;
               if (req_payload.action == cpalu_pkg::ACT_SEED) begin
                  occ_cmd.rd_en  = 1'b1;
                  occ_cmd.rd_row = req_payload.site_y;
                  state_in       = cpalu_pkg::ST_SEED;
               end else if ({1'b0, req_payload.pick_index} >= count_ff) begin
                  state_in = cpalu_pkg::ST_FAIL;
               end else begin
                  list_cmd.rd_en   = 1'b1;
                  list_cmd.rd_addr = req_payload.pick_index;
                  state_in         = cpalu_pkg::ST_PICK;
               end
            end
         end
         cpalu_pkg::ST_PICK: begin
            if ({1'b0, req_ff.uniform} < cfg.death_thr) begin
               site_in          = list_data;
               list_cmd.rd_en   = 1'b1;
               list_cmd.rd_addr = cpalu_pkg::SITE_W'(count_ff - 1'b1);
               occ_cmd.rd_en    = 1'b1;
               occ_cmd.rd_row   = list_data[cpalu_pkg::SITE_W-1:cpalu_pkg::COORD_W];
               state_in         = cpalu_pkg::ST_KILL;
            end else begin
               nx = list_data[cpalu_pkg::COORD_W-1:0];
               ny = list_data[cpalu_pkg::SITE_W-1:cpalu_pkg::COORD_W];
               x1 = {1'b0, nx} + 1'b1;
               y1 = {1'b0, ny} + 1'b1;
               unique case (cpalu_pkg::direction_type'(req_ff.direction))
                  cpalu_pkg::DIR_X_DOWN:
                     nx = (nx == '0) ? cpalu_pkg::COORD_W'(cfg.grid_w - 1'b1) : nx - 1'b1;
                  cpalu_pkg::DIR_X_UP:
                     nx = (x1 >= cfg.grid_w) ? '0 : x1[cpalu_pkg::COORD_W-1:0];
                  cpalu_pkg::DIR_Y_DOWN:
                     ny = (ny == '0) ? cpalu_pkg::COORD_W'(cfg.grid_h - 1'b1) : ny - 1'b1;
                  cpalu_pkg::DIR_Y_UP:
                     ny = (y1 >= cfg.grid_h) ? '0 : y1[cpalu_pkg::COORD_W-1:0];
                  default: ;
               endcase
               site_in        = {ny, nx};
               occ_cmd.rd_en  = 1'b1;
               occ_cmd.rd_row = ny;
               state_in       = cpalu_pkg::ST_GROW;
            end
         end
         cpalu_pkg::ST_KILL: begin
            if (go) begin
               row[x]           = 1'b0;
               occ_cmd.wr_en    = 1'b1;
               occ_cmd.wr_row   = y;
               occ_cmd.wr_data  = row;
               list_cmd.wr_en   = 1'b1;
               list_cmd.wr_addr = req_ff.pick_index;
               list_cmd.wr_data = list_data;
               count_in         = count_ff - 1'b1;
               rsp_in           = {cpalu_pkg::OUT_ANNIHILATED, x, y, count_in};
               rsp_valid_in     = 1'b1;
               state_in         = cpalu_pkg::ST_IDLE;
            end
         end
         cpalu_pkg::ST_GROW: begin
            if (go) begin
               if (!occ_row[x] && !count_ff[cpalu_pkg::COUNT_W-1]) begin
                  row[x]           = 1'b1;
                  occ_cmd.wr_en    = 1'b1;
                  occ_cmd.wr_row   = y;
                  occ_cmd.wr_data  = row;
                  list_cmd.wr_en   = 1'b1;
                  list_cmd.wr_addr = count_ff[cpalu_pkg::SITE_W-1:0];
                  list_cmd.wr_data = site_ff;
                  count_in         = count_ff + 1'b1;
                  rsp_in           = {cpalu_pkg::OUT_CREATED, x, y, count_in};
               end else begin
                  rsp_in = {cpalu_pkg::OUT_NONE, {cpalu_pkg::COORD_W{1'b0}},
                            {cpalu_pkg::COORD_W{1'b0}}, count_ff};
               end
               rsp_valid_in = 1'b1;
               state_in     = cpalu_pkg::ST_IDLE;
            end
         end
         cpalu_pkg::ST_SEED: begin
            if (go) begin
               if ({1'b0, req_ff.site_x} < cfg.grid_w && {1'b0, req_ff.site_y} < cfg.grid_h
                   && !occ_row[req_ff.site_x] && !count_ff[cpalu_pkg::COUNT_W-1]) begin
                  row[req_ff.site_x] = 1'b1;
                  occ_cmd.wr_en      = 1'b1;
                  occ_cmd.wr_row     = req_ff.site_y;
                  occ_cmd.wr_data    = row;
                  list_cmd.wr_en     = 1'b1;
                  list_cmd.wr_addr   = count_ff[cpalu_pkg::SITE_W-1:0];
                  list_cmd.wr_data   = {req_ff.site_y, req_ff.site_x};
                  count_in           = count_ff + 1'b1;
                  rsp_in = {cpalu_pkg::OUT_SEEDED, req_ff.site_x, req_ff.site_y, count_in};
               end else begin
                  rsp_in = {cpalu_pkg::OUT_NONE, {cpalu_pkg::COORD_W{1'b0}},
                            {cpalu_pkg::COORD_W{1'b0}}, count_ff};
               end
               rsp_valid_in = 1'b1;
               state_in     = cpalu_pkg::ST_IDLE;
            end
         end
         cpalu_pkg::ST_FAIL: begin
            if (go) begin
               rsp_in = {cpalu_pkg::OUT_INVALID, {cpalu_pkg::COORD_W{1'b0}},
                         {cpalu_pkg::COORD_W{1'b0}}, count_ff};
               rsp_valid_in = 1'b1;
               state_in     = cpalu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cpalu_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpalu_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      site_ff <= site_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== hw/rtl/contact_process_active_list_update.sv =====
// Contact-process active list update: top level with configuration registers.
// Depends on cpalu_pkg, cpalu_ctrl, cpalu_occ, cpalu_list.
//
// Each request takes one lattice event: a seed request goes through ST_SEED,
// an update through ST_PICK and then ST_KILL or ST_GROW, and an update with
// a bad pick index through ST_FAIL, after which the result sits in an output
// register until taken. The steps follow the synchronous reads of the list
// memory and the occupancy row memory, each read before the write-back. After
// reset the occupancy memory is swept empty one row per cycle, during which no
// request is taken; configuration writes are taken at any time. Grid sizes
// are clamped to 2..64.
module contact_process_active_list_update (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  cpalu_pkg::req_type                    req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output cpalu_pkg::rsp_type                    rsp_payload,
   input  logic                                  csr_we,
   input  logic [cpalu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cpalu_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [cpalu_pkg::SIDE_W-1:0]   width_ff, width_in;
   logic [cpalu_pkg::SIDE_W-1:0]   height_ff, height_in;
   logic [cpalu_pkg::THR_W-1:0]    thresh_ff, thresh_in;
   cpalu_pkg::cfg_type             cfg;
   cpalu_pkg::occ_cmd_type         occ_cmd;
   cpalu_pkg::list_cmd_type        list_cmd;
   logic [cpalu_pkg::MAX_SIDE-1:0] occ_row;
   logic [cpalu_pkg::SITE_W-1:0]   list_data;
   logic                           clearing;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thresh_in = thresh_ff;
      if (csr_we) begin
         unique case (csr_index)
            cpalu_pkg::CSR_GRID_WIDTH:      width_in  = csr_wdata[cpalu_pkg::SIDE_W-1:0];
            cpalu_pkg::CSR_GRID_HEIGHT:     height_in = csr_wdata[cpalu_pkg::SIDE_W-1:0];
            cpalu_pkg::CSR_DEATH_THRESHOLD: thresh_in = csr_wdata[cpalu_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= cpalu_pkg::WIDTH_RESET;
         height_ff <= cpalu_pkg::HEIGHT_RESET;
         thresh_ff <= cpalu_pkg::THRESH_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         thresh_ff <= thresh_in;
      end
   end

   always_comb begin
      priority if (width_ff < cpalu_pkg::SIDE_MIN) cfg.grid_w = cpalu_pkg::SIDE_MIN;
      else if (width_ff > cpalu_pkg::SIDE_MAX)     cfg.grid_w = cpalu_pkg::SIDE_MAX;
      else                                         cfg.grid_w = width_ff;
      priority if (height_ff < cpalu_pkg::SIDE_MIN) cfg.grid_h = cpalu_pkg::SIDE_MIN;
      else if (height_ff > cpalu_pkg::SIDE_MAX)     cfg.grid_h = cpalu_pkg::SIDE_MAX;
      else                                          cfg.grid_h = height_ff;
      cfg.death_thr = thresh_ff;
   end

   cpalu_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .clearing    (clearing),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .occ_cmd     (occ_cmd),
      .occ_row     (occ_row),
      .list_cmd    (list_cmd),
      .list_data   (list_data)
   );

   cpalu_occ u_occ (
      .clock    (clock),
      .reset    (reset),
      .cmd      (occ_cmd),
      .rd_data  (occ_row),
      .clearing (clearing)
   );

   cpalu_list u_list (
      .clock   (clock),
      .cmd     (list_cmd),
      .rd_data (list_data)
   );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for contact_process_active_list_update: predicts each
// lattice event response in-line and compares it with what the block returns.
// Depends on cpalu_pkg and the contact_process_active_list_update RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cpalu_pkg::*;

   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned STALL_LIMIT = 3000;
   localparam int unsigned QUEUE_DEPTH = 6;

   typedef enum int {FLOW_FREE, FLOW_COIN, FLOW_SPARSE, FLOW_BLOCKED} flow_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bit                    occ_map [SITES];
   logic [SITE_W-1:0]     list_mem [SITES];
   int unsigned           live_count = 0;
   logic [SIDE_W-1:0]     width_reg = WIDTH_RESET;
   logic [SIDE_W-1:0]     height_reg = HEIGHT_RESET;
   logic [THR_W-1:0]      thr_reg = THRESH_RESET;

   req_type               pending_req [$];
   rsp_type               expected_rsp [$];
   rsp_type               want;
   int unsigned           items_queued = 0;
   int unsigned           results_seen = 0;
   int unsigned           mismatch_count = 0;
   int unsigned           gap_left = 0;
   int unsigned           burst_left = 0;
   int unsigned           seg_left = 0;
   int unsigned           hold_left = 0;
   int unsigned           idle_cycles = 0;
   bit                    hold_request = 1'b0;
   bit                    hold_taken = 1'b0;
   flow_mode_type         flow_mode = FLOW_FREE;

   contact_process_active_list_update uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int unsigned side_in_use(logic [SIDE_W-1:0] v);
      if (v < SIDE_MIN) return SIDE_MIN;
      if (v > SIDE_MAX) return SIDE_MAX;
      return v;
   endfunction

   function automatic rsp_type predict_event(req_type r);
      int unsigned w;
      int unsigned h;
      int unsigned site;
      int unsigned x;
      int unsigned y;
      int unsigned nx;
      int unsigned ny;
      int unsigned nsite;
      rsp_type     e;
      w = side_in_use(width_reg);
      h = side_in_use(height_reg);
      e = '0;
      if (r.action == ACT_SEED) begin
         if (r.site_x < w && r.site_y < h) begin
            site = r.site_y * MAX_SIDE + r.site_x;
            if (!occ_map[site]) begin
               occ_map[site] = 1'b1;
               list_mem[live_count] = site[SITE_W-1:0];
               live_count++;
               e.outcome = OUT_SEEDED;
               e.changed_x = r.site_x;
               e.changed_y = r.site_y;
            end
         end
      end else if (r.pick_index >= live_count) begin
         e.outcome = OUT_INVALID;
      end else begin
         site = list_mem[r.pick_index];
         x = site % MAX_SIDE;
         y = site / MAX_SIDE;
         if (r.uniform < thr_reg) begin
            occ_map[site] = 1'b0;
            list_mem[r.pick_index] = list_mem[live_count - 1];
            live_count--;
            e.outcome = OUT_ANNIHILATED;
            e.changed_x = x[COORD_W-1:0];
            e.changed_y = y[COORD_W-1:0];
         end else begin
            nx = x;
            ny = y;
            case (r.direction)
               DIR_X_DOWN: nx = (x == 0) ? w - 1 : x - 1;
               DIR_X_UP:   nx = (x + 1 >= w) ? 0 : x + 1;
               DIR_Y_DOWN: ny = (y == 0) ? h - 1 : y - 1;
               default:    ny = (y + 1 >= h) ? 0 : y + 1;
            endcase
            nsite = ny * MAX_SIDE + nx;
            if (!occ_map[nsite]) begin
               occ_map[nsite] = 1'b1;
               list_mem[live_count] = nsite[SITE_W-1:0];
               live_count++;
               e.outcome = OUT_CREATED;
               e.changed_x = nx[COORD_W-1:0];
               e.changed_y = ny[COORD_W-1:0];
            end
         end
      end
      e.occupied_count = live_count[COUNT_W-1:0];
      return e;
   endfunction

   function automatic req_type seed_req(int unsigned x, int unsigned y);
      req_type r;
      r = '0;
      r.action = ACT_SEED;
      r.site_x = x[COORD_W-1:0];
      r.site_y = y[COORD_W-1:0];
      return r;
   endfunction

   function automatic req_type update_req(int unsigned pick, int unsigned uni,
                                          direction_type dir);
      req_type r;
      r = '0;
      r.action = ACT_UPDATE;
      r.pick_index = pick[SITE_W-1:0];
      r.uniform = uni[15:0];
      r.direction = dir;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int unsigned w;
      int unsigned h;
      int unsigned roll;
      int unsigned t;
      w = side_in_use(width_reg);
      h = side_in_use(height_reg);
      r.action = 1'($urandom_range(0, 1));
      r.site_x = COORD_W'($urandom_range(0, 63));
      r.site_y = COORD_W'($urandom_range(0, 63));
      r.pick_index = SITE_W'($urandom_range(0, 4095));
      r.uniform = 16'($urandom_range(0, 65535));
      r.direction = 2'($urandom_range(0, 3));
      roll = $urandom_range(0, 99);
      if (roll < 8) return r;
      if (roll < 30 || live_count == 0) begin
         r.action = ACT_SEED;
         r.site_x = COORD_W'($urandom_range(0, w - 1));
         r.site_y = COORD_W'($urandom_range(0, h - 1));
      end else begin
         r.action = ACT_UPDATE;
         r.pick_index = SITE_W'($urandom_range(0, live_count - 1));
         if (roll < 36) begin
            t = (thr_reg == 0) ? 0 : thr_reg - $urandom_range(0, 1);
            r.uniform = (t > 65535) ? 16'hFFFF : t[15:0];
         end
      end
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned exp_val,
                                       int unsigned act_val);
      if (exp_val != act_val) begin
         mismatch_count++;
         $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
      end
   endfunction

   task automatic queue_request(input req_type r);
      while (pending_req.size() >= QUEUE_DEPTH) @(posedge clock);
      pending_req.push_back(r);
      items_queued++;
   endtask

   task automatic wait_drained();
      while (results_seen < items_queued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      case (idx)
         CSR_GRID_WIDTH:      width_reg = value[SIDE_W-1:0];
         CSR_GRID_HEIGHT:     height_reg = value[SIDE_W-1:0];
         CSR_DEATH_THRESHOLD: thr_reg = value[THR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_grid(input int unsigned w, input int unsigned h,
                           input int unsigned thr);
      write_reg(CSR_GRID_WIDTH, w);
      write_reg(CSR_GRID_HEIGHT, h);
      write_reg(CSR_DEATH_THRESHOLD, thr);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input int unsigned w, input int unsigned h,
                            input int unsigned thr, input int unsigned count,
                            input bit with_hold);
      wait_drained();
      set_grid(w, h, thr);
      for (int unsigned i = 0; i < count; i++) begin
         if (with_hold && i == 100) hold_request = 1'b1;
         queue_request(random_request());
      end
   endtask

   // request driver: bursts with random gaps, payload held while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(predict_event(req_payload));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_req.size() > 0) begin
               req_payload <= pending_req.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  if ($urandom_range(0, 9) < 3) gap_left = 0;
                  else if ($urandom_range(0, 19) == 0) gap_left = 30;
                  else gap_left = $urandom_range(1, 5);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               flow_mode = flow_mode_type'($urandom_range(0, 3));
               seg_left = $urandom_range(1, 40);
            end
            seg_left--;
            case (flow_mode)
               FLOW_FREE:   rsp_stall <= 1'b0;
               FLOW_COIN:   rsp_stall <= 1'($urandom_range(0, 1));
               FLOW_SPARSE: rsp_stall <= ($urandom_range(0, 3) == 0);
               default:     rsp_stall <= 1'b1;
            endcase
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_rsp.size() == 0) begin
            mismatch_count++;
            $display("%0t: response with none expected, actual %h", $time, rsp_payload);
         end else begin
            want = expected_rsp.pop_front();
            check_field("outcome", want.outcome, rsp_payload.outcome);
            check_field("changed_x", want.changed_x, rsp_payload.changed_x);
            check_field("changed_y", want.changed_y, rsp_payload.changed_y);
            check_field("occupied_count", want.occupied_count, rsp_payload.occupied_count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      queue_request(update_req(0, 65535, DIR_X_UP));
      queue_request(seed_req(0, 0));
      queue_request(seed_req(63, 63));
      queue_request(seed_req(0, 0));
      queue_request(seed_req(63, 0));
      queue_request(update_req(0, 65535, DIR_X_DOWN));
      queue_request(update_req(0, 65535, DIR_Y_DOWN));
      queue_request(update_req(1, 65535, DIR_X_UP));
      queue_request(update_req(1, 65535, DIR_Y_DOWN));
      queue_request(update_req(2, 32768, DIR_Y_UP));
      queue_request(update_req(0, 32767, DIR_X_UP));
      queue_request(update_req(4095, 0, DIR_X_UP));
      queue_request(update_req(5, 0, DIR_X_UP));
      queue_request(update_req(4, 0, DIR_Y_UP));

      wait_drained();
      set_grid(3, 2, 0);
      queue_request(seed_req(3, 0));
      queue_request(seed_req(0, 2));
      queue_request(seed_req(2, 1));
      queue_request(update_req(1, 65535, DIR_X_UP));
      queue_request(update_req(1, 65535, DIR_X_DOWN));
      queue_request(update_req(1, 0, DIR_Y_UP));
      queue_request(update_req(1, 40000, DIR_Y_DOWN));
      queue_request(update_req(3, 65535, DIR_X_DOWN));
      queue_request(update_req(4, 65535, DIR_X_UP));

      run_phase(64, 64, 32768, 250, 1'b1);
      run_phase(4, 4, 20000, 200, 1'b0);
      run_phase(127, 1, 0, 150, 1'b0);
      run_phase(0, 64, 131071, 200, 1'b0);
      run_phase(8, 8, 26000, 200, 1'b0);
      run_phase(2, 2, 40000, 150, 1'b0);
      run_phase(65, 5, 65536, 150, 1'b0);
      run_phase(16, 16, 16384, 250, 1'b0);
      run_phase(64, 64, 21845, 250, 1'b0);

      wait_drained();
      repeat (12) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d expected responses never arrived", $time, expected_rsp.size());
      end
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/cpalu_pkg.sv
hw/rtl/cpalu_occ.sv
hw/rtl/cpalu_list.sv
hw/rtl/cpalu_ctrl.sv
hw/rtl/contact_process_active_list_update.sv
dv/testbench.sv
